// ===== rtl/srcm_pkg.sv =====
// package for the stylus response curve map
// holds state codes, register indexes and fixed field widths; no dependencies
package srcm_pkg;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SEG    = 9'b000000010,
    ST_FETCH  = 9'b000000100,
    ST_TEST   = 9'b000001000,
    ST_BIS    = 9'b000010000,
    ST_BWAIT  = 9'b000100000,
    ST_YSTART = 9'b001000000,
    ST_YWAIT  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  // configuration register indexes
  localparam logic [2:0] REG_PRESSURE_ENABLE = 3'd0;
  localparam logic [2:0] REG_TILT_ENABLE     = 3'd1;
  localparam logic [2:0] REG_LINEAR_MODE     = 3'd2;
  localparam logic [2:0] REG_PRESSURE_POINTS = 3'd3;
  localparam logic [2:0] REG_TILT_POINTS     = 3'd4;

  // item function codes
  localparam logic [1:0] FUNC_MAP_PRESSURE = 2'd0;
  localparam logic [1:0] FUNC_MAP_TILT     = 2'd1;
  localparam logic [1:0] FUNC_WR_PRESSURE  = 2'd2;
  localparam logic [1:0] FUNC_WR_TILT      = 2'd3;

  // Q0.16 curve parameter, 1.0 included
  localparam int TW = 17;
  localparam logic [TW-1:0] T_ONE = 17'h10000;

endpackage

// ===== rtl/srcm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module srcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srcm_bez_eval.sv =====
// four-stage cubic bezier evaluator for one coordinate at a Q0.16 parameter
// depends on srcm_pkg; inputs must hold steady until done
module srcm_bez_eval
  import srcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TW-1:0]      t,
  input  logic signed [15:0] p0,
  input  logic signed [15:0] p1,
  input  logic signed [15:0] p2,
  input  logic signed [15:0] p3,
  output logic               done,
  output logic signed [15:0] res
);

  logic [3:0]  v_r;
  logic [16:0] u_r, t_r;
  logic [33:0] u2_r, t2_r;
  logic [32:0] w0_r, w1_r, w2_r, w3_r;
  logic signed [49:0] m0_r, m1_r, m2_r, m3_r;
  logic signed [15:0] res_r;

  logic [50:0] pa, pb, pc, pd;
  logic [52:0] pb3, pc3;
  logic signed [51:0] sum;
  logic signed [19:0] rnd;
  logic [16:0] u_c;

  assign u_c = 17'(T_ONE - t);
  assign pa  = u2_r * u_r;
  assign pb  = u2_r * t_r;
  assign pc  = t2_r * u_r;
  assign pd  = t2_r * t_r;
  assign pb3 = {2'b00, pb} + {1'b0, pb, 1'b0};
  assign pc3 = {2'b00, pc} + {1'b0, pc, 1'b0};
  assign sum = 52'(m0_r) + 52'(m1_r) + 52'(m2_r) + 52'(m3_r) + 52'sh80000000;
  assign rnd = sum[51:32];

  // stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
  end

  // squares, then weights, then weighted points, then rounded sum
  always_ff @(posedge clk) begin
    u_r  <= u_c;
    t_r  <= t;
    u2_r <= u_c * u_c;
    t2_r <= t * t;
    w0_r <= pa[48:16];
    w1_r <= pb3[48:16];
    w2_r <= pc3[48:16];
    w3_r <= pd[48:16];
    m0_r <= $signed({1'b0, w0_r}) * p0;
    m1_r <= $signed({1'b0, w1_r}) * p1;
    m2_r <= $signed({1'b0, w2_r}) * p2;
    m3_r <= $signed({1'b0, w3_r}) * p3;
    if (rnd > 20'sd32767) begin
      res_r <= 16'sh7fff;
    end else if (rnd < -20'sd32768) begin
      res_r <= 16'sh8000;
    end else begin
      res_r <= rnd[15:0];
    end
  end

  assign done = v_r[3];
  assign res  = res_r;

endmodule

// ===== rtl/stylus_response_curve_map.sv =====
// top level of the stylus response curve map
// depends on srcm_pkg, srcm_ram and srcm_bez_eval
//
// Usage: an item is taken when start is high and busy is low. Point write
// items (func 2, 3) go straight into the curve ram at the accepting edge,
// leave busy low and give no result, so one can follow every cycle in
// which busy is low. Map items (func 0, 1) raise busy and end with one
// result on out_mapped and out_segment_hit, marked by out_valid for a
// single cycle; the receiver cannot stall and the next item may be taken
// while that strobe is high. A passthrough map item goes straight to its
// result. Otherwise segments are scanned one at a time, one ram read per
// point (4 cubic, 2 linear), testing the end x values; the holding
// segment adds up to BISECT_STEPS bisection runs of the shared evaluator
// on x, ending early on an exact match, and a final run on y. Configuration
// is written through cfg_valid/cfg_ready (always ready); the user must
// write it only while idle, the block does not enforce this. Reset clears
// the configuration registers and sequencer; the ram holds no reset value
// and curve points must be written before use.
module stylus_response_curve_map
  import srcm_pkg::*;
#(
  parameter int MAX_POINTS   = 64,
  parameter int BISECT_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_sample,
  input  logic [5:0]         in_point_index,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  output logic               out_valid,
  output logic signed [15:0] out_mapped,
  output logic               out_segment_hit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 128) + 1;
  localparam int SW = $clog2(BISECT_STEPS + 1);
  localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

  // configuration registers
  logic       p_en_r, t_en_r, lin_r;
  logic [6:0] p_cnt_r, t_cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_en_r  <= 1'b0;
      t_en_r  <= 1'b0;
      lin_r   <= 1'b0;
      p_cnt_r <= '0;
      t_cnt_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESSURE_ENABLE: p_en_r  <= cfg_data[0];
        REG_TILT_ENABLE:     t_en_r  <= cfg_data[0];
        REG_LINEAR_MODE:     lin_r   <= cfg_data[0];
        REG_PRESSURE_POINTS: p_cnt_r <= cfg_data;
        REG_TILT_POINTS:     t_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t state_r, state_nxt;
  logic               tilt_r, tilt_nxt;
  logic signed [15:0] tgt_r, tgt_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [2:0]         kc_r, kc_nxt;
  logic signed [15:0] px_r [4];
  logic signed [15:0] py_r [4];
  logic [TW-1:0]      t0_r, t0_nxt, t1_r, t1_nxt, tm_r, tm_nxt;
  logic [SW-1:0]      sc_r, sc_nxt;
  logic               d0n_r, d0n_nxt, d0p_r, d0p_nxt;
  logic               ov_r, ov_nxt, hit_r, hit_nxt;
  logic signed [15:0] om_r, om_nxt;

  // ram and evaluator hookup
  logic              accept, we, ev_start, ev_done, ev_y;
  logic [AW:0]       waddr, raddr;
  logic [31:0]       rdata;
  logic [CW-1:0]     slot_ext, ridx, stepw;
  logic [2:0]        nfetch;
  logic signed [15:0] ev_res, e0, e1, e2, e3, samp_abs;
  logic [TW:0]       tsum;
  logic              en_sel;
  logic [CW-1:0]     cnt_sel;

  assign accept   = start && !busy;
  assign slot_ext = CW'(in_point_index);
  assign we       = accept && in_func[1] && (slot_ext < MAXP);
  assign waddr    = {in_func[0], slot_ext[AW-1:0]};
  assign ridx     = i_r + CW'(kc_r);
  assign raddr    = {tilt_r, ridx[AW-1:0]};
  assign stepw    = lin_r ? CW'(1) : CW'(3);
  assign nfetch   = lin_r ? 3'd2 : 3'd4;
  assign tsum     = {1'b0, t0_r} + {1'b0, t1_r};

  srcm_ram #(.WIDTH(32), .DEPTH(2 * MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({in_point_y, in_point_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign e0 = ev_y ? py_r[0] : px_r[0];
  assign e1 = ev_y ? py_r[1] : px_r[1];
  assign e2 = ev_y ? py_r[2] : px_r[2];
  assign e3 = ev_y ? py_r[3] : px_r[3];
  assign ev_y = (state_r == ST_YSTART) || (state_r == ST_YWAIT);

  // the evaluator samples t in its start cycle, so it sees the next midpoint
  srcm_bez_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ev_start),
    .t     (tm_nxt),
    .p0    (e0),
    .p1    (e1),
    .p2    (e2),
    .p3    (e3),
    .done  (ev_done),
    .res   (ev_res)
  );

  // channel selection for a map item, tilt mapped by absolute value
  always_comb begin
    en_sel  = in_func[0] ? t_en_r : p_en_r;
    cnt_sel = CW'(in_func[0] ? t_cnt_r : p_cnt_r);
    if (cnt_sel > MAXP) begin
      cnt_sel = MAXP;
    end
    if (in_func[0] && in_sample[15]) begin
      samp_abs = (in_sample == 16'sh8000) ? 16'sh7fff : -in_sample;
    end else begin
      samp_abs = in_sample;
    end
  end

  // next state logic
  always_comb begin
    state_nxt = state_r;
    tilt_nxt  = tilt_r;
    tgt_nxt   = tgt_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    kc_nxt    = kc_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    tm_nxt    = tm_r;
    sc_nxt    = sc_r;
    d0n_nxt   = d0n_r;
    d0p_nxt   = d0p_r;
    ov_nxt    = 1'b0;
    hit_nxt   = hit_r;
    om_nxt    = om_r;
    ev_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && !in_func[1]) begin
          tilt_nxt = in_func[0];
          tgt_nxt  = samp_abs;
          cnt_nxt  = cnt_sel;
          i_nxt    = '0;
          if (!en_sel || cnt_sel == '0) begin
            om_nxt    = in_sample;
            hit_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        kc_nxt = '0;
        if (i_r + stepw < cnt_r) begin
          state_nxt = ST_FETCH;
        end else begin
          om_nxt    = tgt_r;
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_FETCH: begin
        kc_nxt = kc_r + 3'd1;
        if (kc_r == nfetch) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if ((tgt_r >= px_r[0] && tgt_r <= px_r[3]) ||
            (tgt_r >= px_r[3] && tgt_r <= px_r[0])) begin
          t0_nxt    = '0;
          t1_nxt    = T_ONE;
          sc_nxt    = '0;
          d0n_nxt   = px_r[0] < tgt_r;
          d0p_nxt   = px_r[0] > tgt_r;
          state_nxt = ST_BIS;
        end else begin
          i_nxt     = i_r + stepw;
          state_nxt = ST_SEG;
        end
      end
      ST_BIS: begin
        tm_nxt = tsum[TW:1];
        if (sc_r == SW'(BISECT_STEPS)) begin
          state_nxt = ST_YSTART;
        end else begin
          state_nxt = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        ev_start = (sc_r != '1) && 1'b0;
        if (ev_done) begin
          if (ev_res == tgt_r) begin
            state_nxt = ST_YSTART;
          end else begin
            if ((d0n_r && ev_res > tgt_r) || (d0p_r && ev_res < tgt_r)) begin
              t1_nxt = tm_r;
            end else begin
              t0_nxt = tm_r;
            end
            sc_nxt    = sc_r + SW'(1);
            state_nxt = ST_BIS;
          end
        end
      end
      ST_YSTART: begin
        state_nxt = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (ev_done) begin
          om_nxt    = ev_res;
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // evaluator kicks off on entry to a wait state
    if ((state_r == ST_BIS && sc_r != SW'(BISECT_STEPS)) || state_r == ST_YSTART) begin
      ev_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tilt_r <= tilt_nxt;
    tgt_r  <= tgt_nxt;
    cnt_r  <= cnt_nxt;
    i_r    <= i_nxt;
    kc_r   <= kc_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    tm_r   <= tm_nxt;
    sc_r   <= sc_nxt;
    d0n_r  <= d0n_nxt;
    d0p_r  <= d0p_nxt;
    hit_r  <= hit_nxt;
    om_r   <= om_nxt;
    // point capture, in the cycle after each read
    if (state_r == ST_FETCH && kc_r != 3'd0) begin
      if (lin_r) begin
        if (kc_r == 3'd1) begin
          px_r[0] <= rdata[15:0];
          px_r[1] <= rdata[15:0];
          py_r[0] <= rdata[31:16];
          py_r[1] <= rdata[31:16];
        end else begin
          px_r[2] <= rdata[15:0];
          px_r[3] <= rdata[15:0];
          py_r[2] <= rdata[31:16];
          py_r[3] <= rdata[31:16];
        end
      end else begin
        px_r[2'(kc_r - 3'd1)] <= rdata[15:0];
        py_r[2'(kc_r - 3'd1)] <= rdata[31:16];
      end
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_mapped      = om_r;
  assign out_segment_hit = hit_r;

endmodule

// ===== dv/testbench.sv =====
// testbench for the stylus response curve map: command items in, strobed results out
// depends on srcm_pkg and the rtl top stylus_response_curve_map; predicts every result
// in a scoreboard class and checks each strobe against the oldest expected one
module testbench
  import srcm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int STEPS = 16;

  typedef struct {
    logic signed [15:0] mapped;
    logic               hit;
  } curve_result_t;

  // curve mirror, expected result store and checker
  class curve_scoreboard;
    logic [31:0]   press_tab [NPTS];
    logic [31:0]   tilt_tab [NPTS];
    bit            press_en, tilt_en, lin_mode;
    int unsigned   press_cnt, tilt_cnt;
    curve_result_t expected_q[$];
    int            errors;

    function void clear();
      press_en = 0; tilt_en = 0; lin_mode = 0;
      press_cnt = 0; tilt_cnt = 0;
      errors = 0;
      foreach (press_tab[k]) begin
        press_tab[k] = '0;
        tilt_tab[k] = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [6:0] val);
      case (idx)
        REG_PRESSURE_ENABLE: press_en = val[0];
        REG_TILT_ENABLE:     tilt_en = val[0];
        REG_LINEAR_MODE:     lin_mode = val[0];
        REG_PRESSURE_POINTS: press_cnt = val;
        REG_TILT_POINTS:     tilt_cnt = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one axis of a cubic at q0.16 t, rounded half up to an integer (q15.0 like the points)
    function int axis_at(int p[4], int unsigned t);
      logic [63:0] tt, u, w0, w1, w2, w3;
      longint s;
      tt = t;
      u = 64'd65536 - tt;
      w0 = (u * u * u) >> 16;
      w1 = (64'd3 * u * u * tt) >> 16;
      w2 = (64'd3 * u * tt * tt) >> 16;
      w3 = (tt * tt * tt) >> 16;
      s = longint'(w0) * p[0] + longint'(w1) * p[1] + longint'(w2) * p[2]
          + longint'(w3) * p[3];
      s = (s + (longint'(1) << 31)) >>> 32;
      return int'(s);
    endfunction

    // scan segments in order, bisect the first one holding target
    function bit curve_search(bit tilt, int unsigned cnt, int target, output int y);
      int unsigned stride, i, t0, t1, tm, root;
      int px[4], py[4], ix[4], x0, x1, xm, k;
      longint d0;
      bit found;
      logic [31:0] e;
      stride = lin_mode ? 1 : 3;
      y = 0;
      for (i = 0; i + stride < cnt; i += stride) begin
        ix[0] = i;
        ix[1] = lin_mode ? i : i + 1;
        ix[2] = lin_mode ? i + 1 : i + 2;
        ix[3] = lin_mode ? i + 1 : i + 3;
        for (k = 0; k < 4; k++) begin
          e = tilt ? tilt_tab[ix[k] % NPTS] : press_tab[ix[k] % NPTS];
          px[k] = int'($signed(e[15:0]));
          py[k] = int'($signed(e[31:16]));
        end
        x0 = axis_at(px, 0);
        x1 = axis_at(px, 65536);
        if (!((target >= x0 && target <= x1) || (target >= x1 && target <= x0)))
          continue;
        d0 = longint'(x0) - target;
        if (d0 * (longint'(x1) - target) > 0)
          continue;
        t0 = 0; t1 = 65536; root = 0; found = 0;
        for (k = 0; k < STEPS && !found; k++) begin
          tm = (t0 + t1) >> 1;
          xm = axis_at(px, tm);
          if (xm == target) begin
            root = tm;
            found = 1;
          end else if (d0 * (longint'(xm) - target) < 0) begin
            t1 = tm;
          end else begin
            t0 = tm;
          end
        end
        if (!found)
          root = (t0 + t1) >> 1;
        y = axis_at(py, root);
        return 1;
      end
      return 0;
    endfunction

    // accepted item: update tables or predict the mapped result
    function void note_item(logic [1:0] fn, logic signed [15:0] smp, logic [5:0] idx,
                            logic signed [15:0] px, logic signed [15:0] py);
      curve_result_t r;
      bit tilt, en;
      int unsigned cnt;
      int target, y;
      tilt = (fn == FUNC_MAP_TILT) || (fn == FUNC_WR_TILT);
      if (fn == FUNC_WR_PRESSURE || fn == FUNC_WR_TILT) begin
        if (tilt) tilt_tab[idx] = {py, px};
        else press_tab[idx] = {py, px};
        return;
      end
      en = tilt ? tilt_en : press_en;
      cnt = tilt ? tilt_cnt : press_cnt;
      if (cnt > NPTS) cnt = NPTS;
      r.mapped = smp;
      r.hit = 0;
      if (en && cnt > 0) begin
        target = smp;
        if (tilt && target < 0)
          target = (target == -32768) ? 32767 : -target;
        r.mapped = target;
        if (curve_search(tilt, cnt, target, y)) begin
          if (y > 32767) y = 32767;
          if (y < -32768) y = -32768;
          r.mapped = y;
          r.hit = 1;
        end
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_result(logic signed [15:0] mapped, logic hit);
      curve_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result mapped=%0d hit=%0b", mapped, hit);
        return;
      end
      r = expected_q.pop_front();
      if (mapped !== r.mapped || hit !== r.hit) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected mapped=%0d hit=%0b, got mapped=%0d hit=%0b",
                   r.mapped, r.hit, mapped, hit);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_func = '0;
  logic signed [15:0] in_sample = '0;
  logic [5:0] in_point_index = '0;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic out_valid;
  logic signed [15:0] out_mapped;
  logic out_segment_hit;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  curve_scoreboard sb;
  int idle_pct;

  stylus_response_curve_map dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_sample(in_sample), .in_point_index(in_point_index),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_mapped(out_mapped), .out_segment_hit(out_segment_hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_mapped, out_segment_hit);
  end

  // present one item, hold until taken; start stays high for a following item
  task automatic send_item(logic [1:0] fn, logic signed [15:0] smp, logic [5:0] idx,
                           logic signed [15:0] px, logic signed [15:0] py);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    in_func <= fn;
    in_sample <= smp;
    in_point_index <= idx;
    in_point_x <= px;
    in_point_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(fn, smp, idx, px, py);
  endtask

  task automatic map_item(logic [1:0] fn, logic signed [15:0] smp);
    send_item(fn, smp, 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // let the block go quiet before touching registers
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // valid stays high across back to back writes; the caller drops it
  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_curve(bit pe, bit te, bit lin, logic [6:0] pp, logic [6:0] tp);
    drain();
    write_reg(REG_PRESSURE_ENABLE, 7'(pe));
    write_reg(REG_TILT_ENABLE, 7'(te));
    write_reg(REG_LINEAR_MODE, 7'(lin));
    write_reg(REG_PRESSURE_POINTS, pp);
    write_reg(REG_TILT_POINTS, tp);
    cfg_valid <= 0;
  endtask

  // ascending x with jitter, random y
  task automatic load_table(logic [1:0] fn, int base, int spacing);
    for (int k = 0; k < NPTS; k++)
      send_item(fn, 16'($urandom), 6'(k), 16'(base + k * spacing + $urandom_range(0, 199)),
                16'($urandom));
  endtask

  task automatic random_items(int n);
    int r, base;
    logic [1:0] fn;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        fn = $urandom_range(1) ? FUNC_MAP_TILT : FUNC_MAP_PRESSURE;
        base = (fn == FUNC_MAP_TILT) ? 0 : -16000;
        if ($urandom_range(99) < 75) begin
          r = base + $urandom_range(0, 63 * 500);
          if (fn == FUNC_MAP_TILT && $urandom_range(1)) r = -r;
          map_item(fn, 16'(r));
        end else begin
          map_item(fn, 16'($urandom));
        end
      end else if (r < 90) begin
        // in-order rewrite that keeps the curve well formed
        fn = $urandom_range(1) ? FUNC_WR_TILT : FUNC_WR_PRESSURE;
        base = (fn == FUNC_WR_TILT) ? 0 : -16000;
        r = $urandom_range(0, 63);
        send_item(fn, 16'($urandom), 6'(r),
                  16'(base + r * 500 + $urandom_range(0, 199)), 16'($urandom));
      end else begin
        // noise point anywhere
        fn = $urandom_range(1) ? FUNC_WR_TILT : FUNC_WR_PRESSURE;
        send_item(fn, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    sb.clear();
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // passthrough while disabled and empty
    map_item(FUNC_MAP_PRESSURE, 16'sh7fff);
    map_item(FUNC_MAP_TILT, -16'sd32768);
    set_curve(1, 1, 0, 0, 0);
    map_item(FUNC_MAP_TILT, -16'sd5);

    load_table(FUNC_WR_PRESSURE, -16000, 500);
    load_table(FUNC_WR_TILT, 0, 500);

    // directed: extremes, tilt sign, too few points, one point
    set_curve(1, 1, 0, 64, 64);
    map_item(FUNC_MAP_PRESSURE, 16'sh7fff);
    map_item(FUNC_MAP_PRESSURE, -16'sd32768);
    map_item(FUNC_MAP_PRESSURE, 16'sd0);
    map_item(FUNC_MAP_PRESSURE, -16'sd15990);
    map_item(FUNC_MAP_TILT, -16'sd32768);
    map_item(FUNC_MAP_TILT, -16'sd1000);
    map_item(FUNC_MAP_TILT, 16'sd1000);
    map_item(FUNC_MAP_TILT, -16'sd1);
    set_curve(1, 1, 0, 3, 1);
    map_item(FUNC_MAP_PRESSURE, -16'sd15500);
    map_item(FUNC_MAP_TILT, -16'sd100);
    set_curve(1, 1, 1, 2, 127);
    map_item(FUNC_MAP_PRESSURE, -16'sd15800);
    map_item(FUNC_MAP_TILT, 16'sd20000);
    map_item(FUNC_MAP_TILT, 16'sh7fff);

    // random phases over settings and idling
    idle_pct = 0;  set_curve(1, 1, 0, 64, 64);  random_items(100);
    idle_pct = 82; set_curve(1, 1, 1, 64, 64);  random_items(100);
    idle_pct = 0;  set_curve(1, 0, 0, 127, 7);  random_items(100);
    idle_pct = 18; set_curve(0, 1, 1, 2, 100);  random_items(100);
    idle_pct = 82; set_curve(1, 1, 0, 4, 1);    random_items(100);
    idle_pct = 18; set_curve(1, 1, 1, 33, 64);  random_items(100);

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
